// ===== src/cla_pkg.sv =====
// Shared types and constants for the contig link accumulator.
// Field widths, the slot layout of one memory row, result struct and states.
// No dependencies.
package cla_pkg;

   // field widths
   localparam int SRC_W    = 12;
   localparam int TARGET_W = 12;
   localparam int GAP_W    = 16;
   localparam int COUNT_W  = 10;
   localparam int SUM_W    = 26;

   // count saturation point and cutoff after reset
   localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 10'd1023;
   localparam logic [COUNT_W-1:0] CUTOFF_RESET = 10'd3;

   // one list entry; count of zero marks an unused slot
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
   } cla_slot_type;

   localparam int SLOT_W = $bits(cla_slot_type);

   // result of one row update
   typedef struct packed {
      logic [COUNT_W-1:0] support_count;
      logic [SUM_W-1:0]   gap_total;
      logic               entry_created;
      logic               list_full;
      logic               is_supported;
   } cla_result_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } cla_state_type;

endpackage

// ===== src/cla_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cla_row_update.sv =====
// Modify step for one source row: target lookup, saturating update or append.
// Depends on cla_pkg.
module cla_row_update #(
   parameter int LINKS_PER_NODE = 8
) (
   input  cla_pkg::cla_slot_type [LINKS_PER_NODE-1:0] row_in,
   input  logic [cla_pkg::TARGET_W-1:0]               target,
   input  logic [cla_pkg::GAP_W-1:0]                  gap,
   input  logic [cla_pkg::COUNT_W-1:0]                cutoff,
   input  logic                                       in_range,
   output cla_pkg::cla_slot_type [LINKS_PER_NODE-1:0] row_out,
   output logic                                       row_write,
   output cla_pkg::cla_result_type                    result
);
   import cla_pkg::*;

   logic [LINKS_PER_NODE-1:0] hit_oh;
   logic [LINKS_PER_NODE-1:0] free_oh;
   logic [LINKS_PER_NODE-1:0] upd_oh;
   logic                      hit_any;
   logic                      free_any;
   cla_slot_type              hit_slot;
   cla_slot_type              new_slot;
   logic [SUM_W-1:0]          gap_ext;

   assign gap_ext = {{(SUM_W-GAP_W){gap[GAP_W-1]}}, gap};

   // first matching slot and first unused slot, one-hot
   always_comb begin
      hit_oh   = '0;
      free_oh  = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < LINKS_PER_NODE; i++) begin
         if (!hit_any && row_in[i].count != '0 && row_in[i].target == target) begin
            hit_oh[i] = 1'b1;
            hit_any   = 1'b1;
            hit_slot  = row_in[i];
         end
         if (!free_any && row_in[i].count == '0) begin
            free_oh[i] = 1'b1;
            free_any   = 1'b1;
         end
      end
   end

   // new slot contents and result
   always_comb begin
      new_slot  = hit_slot;
      upd_oh    = '0;
      row_write = 1'b0;
      result    = '0;
      if (!in_range) begin
         result = '0;
      end else if (hit_any) begin
         // count freezes at the limit, sum with it
         if (hit_slot.count < COUNT_LIMIT) begin
            new_slot.count = hit_slot.count + COUNT_W'(1);
            new_slot.sum   = hit_slot.sum + gap_ext;
            upd_oh         = hit_oh;
            row_write      = 1'b1;
         end
         result.support_count = new_slot.count;
         result.gap_total     = new_slot.sum;
         result.is_supported  = (new_slot.count >= cutoff);
      end else if (free_any) begin
         new_slot.target      = target;
         new_slot.count       = COUNT_W'(1);
         new_slot.sum         = gap_ext;
         upd_oh               = free_oh;
         row_write            = 1'b1;
         result.support_count = COUNT_W'(1);
         result.gap_total     = gap_ext;
         result.entry_created = 1'b1;
         result.is_supported  = (COUNT_W'(1) >= cutoff);
      end else begin
         result.list_full = 1'b1;
      end
   end

   // merge the touched slot into the row
   always_comb begin
      for (int i = 0; i < LINKS_PER_NODE; i++) begin
         row_out[i] = upd_oh[i] ? new_slot : row_in[i];
      end
   end

endmodule

// ===== src/contig_link_accumulator.sv =====
// Contig link accumulator: per-source bounded link lists kept in one row memory.
// The row is read when the item is accepted and the result is registered from the
// update state, so rsp_valid rises once the update state finds the output free.
// No new item is taken until the read-modify-write of the last item's row through
// the row memory is done; a stalled result output holds the update state.
// Reset: clears the cutoff to 3 and runs a clearing pass over all NODE_COUNT rows
// of the row memory, during which no item is accepted (csr writes still are).
module contig_link_accumulator #(
   parameter int NODE_COUNT     = 4096,
   parameter int LINKS_PER_NODE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cla_pkg::COUNT_W-1:0]   csr_support_cutoff,
   // items in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cla_pkg::SRC_W-1:0]     req_source_node,
   input  logic [cla_pkg::TARGET_W-1:0]  req_target_node,
   input  logic [cla_pkg::GAP_W-1:0]     req_gap_estimate,
   // results out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cla_pkg::COUNT_W-1:0]   rsp_support_count,
   output logic [cla_pkg::SUM_W-1:0]     rsp_gap_total,
   output logic                          rsp_entry_created,
   output logic                          rsp_list_full,
   output logic                          rsp_is_supported
);
   import cla_pkg::*;

   localparam int ROW_W  = LINKS_PER_NODE * SLOT_W;
   localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   cla_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]     cutoff_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [TARGET_W-1:0]    target_ff;
   logic [GAP_W-1:0]       gap_ff;
   logic                   range_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   cla_result_type         rsp_ff;

   logic                   req_accept;
   logic                   rsp_load;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [ROW_W-1:0]       mem_wr_data;
   logic [ROW_W-1:0]       mem_rd_data;
   logic                   row_write;
   cla_slot_type [LINKS_PER_NODE-1:0] row_rd;
   cla_slot_type [LINKS_PER_NODE-1:0] row_upd;
   cla_result_type         upd_result;
   logic                   clr_last;

   assign req_accept = req_valid && req_ready;
   assign clr_last   = (clr_addr_ff == ADDR_W'(NODE_COUNT - 1));

   // configuration register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_valid && csr_ready) begin
         cutoff_ff <= csr_support_cutoff;
      end
   end

   // row memory
   cla_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODE_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_accept),
      .rd_addr (ADDR_W'(req_source_node)),
      .rd_data (mem_rd_data)
   );

   assign row_rd = mem_rd_data;

   // row modify
   cla_row_update #(
      .LINKS_PER_NODE (LINKS_PER_NODE)
   ) u_row_update (
      .row_in    (row_rd),
      .target    (target_ff),
      .gap       (gap_ff),
      .cutoff    (cutoff_ff),
      .in_range  (range_ff),
      .row_out   (row_upd),
      .row_write (row_write),
      .result    (upd_result)
   );

   // hold the accepted item for the update cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff   <= ADDR_W'(req_source_node);
         target_ff <= req_target_node;
         gap_ff    <= req_gap_estimate;
         range_ff  <= (32'(req_source_node) < 32'(NODE_COUNT));
      end
   end

   // state and clear address registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // next state, handshake and memory write control
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = row_upd;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_last) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait here while the output register still holds a result
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load  = 1'b1;
               mem_wr_en = row_write;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= upd_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_support_count = rsp_ff.support_count;
   assign rsp_gap_total     = rsp_ff.gap_total;
   assign rsp_entry_created = rsp_ff.entry_created;
   assign rsp_list_full     = rsp_ff.list_full;
   assign rsp_is_supported  = rsp_ff.is_supported;

`ifndef SYNTHESIS
   // an accepted item always moves to the update cycle
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPDATE))
      else $error("accepted item did not enter update");

   // memory writes only come from the clear pass or an update
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("row memory written outside clear or update");

   // a dropped item reports nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_list_full) |->
         (rsp_support_count == '0 && !rsp_entry_created && !rsp_is_supported))
      else $error("full-list result carries entry data");

   // a new entry always starts at count one
   a_created_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_created) |-> (rsp_support_count == COUNT_W'(1)))
      else $error("created entry with count other than one");
`endif

endmodule
